FILE: rtl/sbpp_pkg.sv
// shared types and constants of the spectral band peak picker
package sbpp_pkg;

	localparam int NUM_BANDS = 6;
	localparam int NUM_EDGES = 5;
	localparam int EDGE_W    = 13;
	localparam int BIN_OUT_W = 12;
	localparam int MAG_OUT_W = 16;
	localparam int WIN_W     = 16;
	localparam int SUM_W     = MAG_OUT_W + 3;
	localparam int CNT_W     = 3;

	// configuration register indexes
	localparam logic [2:0] REG_EDGE_ONE   = 3'd0;
	localparam logic [2:0] REG_EDGE_TWO   = 3'd1;
	localparam logic [2:0] REG_EDGE_THREE = 3'd2;
	localparam logic [2:0] REG_EDGE_FOUR  = 3'd3;
	localparam logic [2:0] REG_EDGE_FIVE  = 3'd4;

	localparam logic [EDGE_W-1:0] EDGE_ONE_RST   = 13'd409;
	localparam logic [EDGE_W-1:0] EDGE_TWO_RST   = 13'd1024;
	localparam logic [EDGE_W-1:0] EDGE_THREE_RST = 13'd1638;
	localparam logic [EDGE_W-1:0] EDGE_FOUR_RST  = 13'd2457;
	localparam logic [EDGE_W-1:0] EDGE_FIVE_RST  = 13'd3276;

	typedef logic [NUM_EDGES-1:0][EDGE_W-1:0] edges_t;

	// band results of one finished window
	typedef struct packed {
		logic [NUM_BANDS-1:0][MAG_OUT_W-1:0] mag;
		logic [NUM_BANDS-1:0][BIN_OUT_W-1:0] bin;
		logic [NUM_BANDS-1:0]                found;
		logic [WIN_W-1:0]                    window;
	} win_rec_t;

	// queue status seen by the back part
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: rtl/sbpp_front.sv
// front part: bin counting and per-band peak tracking over one window
module sbpp_front #(
	parameter int MAX_BINS = 4096,
	parameter int MAG_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [15:0]               magnitude,
	input  logic                      window_end,
	input  sbpp_pkg::edges_t          edges,
	output logic                      push,
	output sbpp_pkg::win_rec_t        rec
);
	import sbpp_pkg::*;

	localparam int BIN_W = $clog2(MAX_BINS);
	localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(MAX_BINS - 1);
	localparam logic [15:0] MAG_MASK =
		(MAG_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << MAG_BITS) - 32'd1);

	logic [BIN_W-1:0]                     bin_q;
	logic [WIN_W-1:0]                     window_q;
	logic [NUM_BANDS-1:0][MAG_OUT_W-1:0]  best_mag_q, best_mag_nx;
	logic [NUM_BANDS-1:0][BIN_OUT_W-1:0]  best_bin_q, best_bin_nx;
	logic [NUM_BANDS-1:0]                 found_q, found_nx;
	logic [15:0]                          mag_in;
	logic [EDGE_W-1:0]                    bin_ext;
	logic [NUM_BANDS-1:0]                 in_band;

	assign mag_in  = magnitude & MAG_MASK;
	assign bin_ext = EDGE_W'(bin_q);

	always_comb begin
		for (int k = 0; k < NUM_BANDS; k++) begin
			in_band[k] = 1'b1;
			if (k > 0 && bin_ext < edges[(k > 0) ? k - 1 : 0])
				in_band[k] = 1'b0;
			if (k < NUM_BANDS - 1 && !(bin_ext < edges[(k < NUM_EDGES) ? k : 0]))
				in_band[k] = 1'b0;
		end
	end

	always_comb begin
		best_mag_nx = best_mag_q;
		best_bin_nx = best_bin_q;
		found_nx    = found_q;
		for (int k = 0; k < NUM_BANDS; k++) begin
			if (in_band[k] && mag_in > best_mag_q[k]) begin
				best_mag_nx[k] = mag_in;
				best_bin_nx[k] = BIN_OUT_W'(bin_q);
				found_nx[k]    = 1'b1;
			end
		end
	end

	assign push         = accept & window_end;
	assign rec.mag      = best_mag_nx;
	assign rec.bin      = best_bin_nx;
	assign rec.found    = found_nx;
	assign rec.window   = window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q      <= '0;
			window_q   <= '0;
			best_mag_q <= '0;
			best_bin_q <= '0;
			found_q    <= '0;
		end else if (accept) begin
			if (window_end) begin
				bin_q      <= '0;
				window_q   <= window_q + 1'b1;
				best_mag_q <= '0;
				best_bin_q <= '0;
				found_q    <= '0;
			end else begin
				if (bin_q != BIN_LAST)
					bin_q <= bin_q + 1'b1;
				best_mag_q <= best_mag_nx;
				best_bin_q <= best_bin_nx;
				found_q    <= found_nx;
			end
		end
	end

endmodule

FILE: rtl/sbpp_queue.sv
// two-entry queue of finished window records between front and back
module sbpp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sbpp_pkg::win_rec_t  wr_rec,
	input  logic                pop,
	output sbpp_pkg::win_rec_t  rd_rec,
	output sbpp_pkg::q_status_t status
);
	import sbpp_pkg::*;

	win_rec_t    mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign do_push      = push & ~status.full;
	assign do_pop       = pop & ~status.empty;
	assign rd_rec       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/sbpp_back.sv
// back part: averages band peaks of a window and emits those above it
module sbpp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sbpp_pkg::win_rec_t                  head,
	input  logic                                q_empty,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sbpp_pkg::BIN_OUT_W-1:0]      peak_bin,
	output logic [sbpp_pkg::WIN_W-1:0]          peak_window,
	output logic [sbpp_pkg::MAG_OUT_W-1:0]      peak_magnitude,
	output logic                                run_last
);
	import sbpp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCORE = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t                  state_q;
	win_rec_t                rec_q;
	logic [SUM_W-1:0]        sum_q, sum_nx;
	logic [CNT_W-1:0]        cnt_q, cnt_nx;
	logic [NUM_BANDS-1:0]    keep;
	logic [NUM_BANDS-1:0]    pend_q;
	logic [NUM_BANDS-1:0]    low_bit;
	logic [2:0]              low_idx;
	logic                    out_valid_q;
	logic                    out_free;
	logic                    is_last;

	// sum and count of the found band peaks
	always_comb begin
		sum_nx = '0;
		cnt_nx = '0;
		for (int k = 0; k < NUM_BANDS; k++) begin
			if (head.found[k]) begin
				sum_nx = sum_nx + SUM_W'(head.mag[k]);
				cnt_nx = cnt_nx + 1'b1;
			end
		end
	end

	// peak times count above sum means above the average
	always_comb begin
		for (int k = 0; k < NUM_BANDS; k++)
			keep[k] = rec_q.found[k] &&
				((SUM_W'(rec_q.mag[k]) * SUM_W'(cnt_q)) > sum_q);
	end

	always_comb begin
		low_idx = '0;
		for (int k = NUM_BANDS - 1; k >= 0; k--) begin
			if (pend_q[k])
				low_idx = 3'(k);
		end
	end

	assign low_bit  = NUM_BANDS'(1) << low_idx;
	assign is_last  = ((pend_q & ~low_bit) == '0);
	assign out_free = ~out_valid_q | ~out_stall;
	assign pop      = (state_q == ST_IDLE) & ~q_empty;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty)
						state_q <= ST_SCORE;
				end
				ST_SCORE: begin
					pend_q  <= keep;
					state_q <= (keep == '0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						pend_q <= pend_q & ~low_bit;
						if (is_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head;
			sum_q <= sum_nx;
			cnt_q <= cnt_nx;
		end
		if (state_q == ST_EMIT && out_free) begin
			peak_bin       <= rec_q.bin[low_idx];
			peak_window    <= rec_q.window;
			peak_magnitude <= rec_q.mag[low_idx];
			run_last       <= is_last;
		end
	end

endmodule

FILE: rtl/spectral_band_peak_picker_core.sv
// top level of the spectral band peak picker with its register port
// Usage:
// - bins stream in on in_valid / in_stall, low to high frequency, one item
//   per bin; window_end marks the last bin of a time window
// - five band edges are written over the register port at 0x00..0x10
// - one output item per band peak strictly above the window's average,
//   in band order, run_last on the last of them; none for an empty window
// - one bin is taken per cycle; in_stall rises only on a window_end item
//   while both window records of the queue still wait for the back part
// - the back part takes a record with its sum and count, compares in its
//   score state, then emits one peak per cycle while the output is not
//   stalled, so a window of at least 8 bins sustains one bin per cycle
// - output stall holds the output register and pauses emission; the queue
//   lets bins of the next window keep flowing meanwhile
// - reset clears counters, band trackers, queue and output valid and
//   loads the default band edges
module spectral_band_peak_picker_core #(
	parameter int MAX_BINS = 4096,
	parameter int MAG_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] magnitude,
	input  logic        window_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] peak_bin,
	output logic [15:0] peak_window,
	output logic [15:0] peak_magnitude,
	output logic        run_last
);
	import sbpp_pkg::*;

	edges_t     edges_q;
	logic [2:0] reg_idx;
	logic       reg_wr;
	logic       accept;
	logic       push;
	logic       pop;
	win_rec_t   front_rec;
	win_rec_t   head_rec;
	q_status_t  q_status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel & penable & pwrite;

	always_comb begin
		case (reg_idx)
			REG_EDGE_ONE:   prdata = 32'(edges_q[0]);
			REG_EDGE_TWO:   prdata = 32'(edges_q[1]);
			REG_EDGE_THREE: prdata = 32'(edges_q[2]);
			REG_EDGE_FOUR:  prdata = 32'(edges_q[3]);
			REG_EDGE_FIVE:  prdata = 32'(edges_q[4]);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_q[0] <= EDGE_ONE_RST;
			edges_q[1] <= EDGE_TWO_RST;
			edges_q[2] <= EDGE_THREE_RST;
			edges_q[3] <= EDGE_FOUR_RST;
			edges_q[4] <= EDGE_FIVE_RST;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_EDGE_ONE:   edges_q[0] <= pwdata[EDGE_W-1:0];
				REG_EDGE_TWO:   edges_q[1] <= pwdata[EDGE_W-1:0];
				REG_EDGE_THREE: edges_q[2] <= pwdata[EDGE_W-1:0];
				REG_EDGE_FOUR:  edges_q[3] <= pwdata[EDGE_W-1:0];
				REG_EDGE_FIVE:  edges_q[4] <= pwdata[EDGE_W-1:0];
				default:        edges_q    <= edges_q;
			endcase
		end
	end

	// only a window end item needs room in the queue
	assign in_stall = window_end & q_status.full;
	assign accept   = in_valid & ~in_stall;

	sbpp_front #(
		.MAX_BINS (MAX_BINS),
		.MAG_BITS (MAG_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.magnitude  (magnitude),
		.window_end (window_end),
		.edges      (edges_q),
		.push       (push),
		.rec        (front_rec)
	);

	sbpp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (front_rec),
		.pop    (pop),
		.rd_rec (head_rec),
		.status (q_status)
	);

	sbpp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head_rec),
		.q_empty        (q_status.empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.peak_bin       (peak_bin),
		.peak_window    (peak_window),
		.peak_magnitude (peak_magnitude),
		.run_last       (run_last)
	);

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the spectral band peak picker core
`timescale 1ns / 100ps

module testbench;
	import sbpp_pkg::*;

	localparam int CYCLE_LIMIT = 100_000;
	localparam int MAX_BIN_INDEX = 4095;
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_HALF, STALL_TOGGLE} stall_mode_t;

	typedef struct packed {
		logic [BIN_OUT_W-1:0] bin;
		logic [WIN_W-1:0]     window;
		logic [MAG_OUT_W-1:0] mag;
		logic                 last;
	} peak_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] magnitude = '0;
	logic        window_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [11:0] peak_bin;
	logic [15:0] peak_window;
	logic [15:0] peak_magnitude;
	logic        run_last;

	// predictor state
	logic [EDGE_W-1:0]    band_edge [NUM_EDGES];
	logic [BIN_OUT_W-1:0] bin_count;
	logic [WIN_W-1:0]     window_count;
	logic [MAG_OUT_W-1:0] best_mag [NUM_BANDS];
	logic [BIN_OUT_W-1:0] best_bin [NUM_BANDS];
	logic                 band_hit [NUM_BANDS];
	peak_t                expected_peaks [$];

	int          mismatches = 0;
	int          peaks_checked = 0;
	int          bins_sent = 0;
	int          windows_sent = 0;
	int          reg_writes = 0;
	int unsigned cycle_count = 0;
	int          burst_left = 0;
	bit          sender_gaps = 1'b1;
	int          hold_request = 0;
	int          hold_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	spectral_band_peak_picker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.magnitude(magnitude),
		.window_end(window_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.peak_bin(peak_bin),
		.peak_window(peak_window),
		.peak_magnitude(peak_magnitude),
		.run_last(run_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d peaks pending", cycle_count,
			expected_peaks.size());
		$display("** spectral_band_peak_picker_core: FAILED **");
		$finish;
	end

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		if (mismatches < 40) begin
			$display("mismatch in %s: got 0x%0h, expected 0x%0h (cycle %0d)", what, got, want,
				cycle_count);
		end
		mismatches++;
	endtask

	// band tracking and window-end selection for one accepted item
	function automatic void track_bin(logic [MAG_OUT_W-1:0] mag, logic last);
		logic [EDGE_W-1:0] lo;
		logic [EDGE_W-1:0] bin_wide;
		int unsigned total;
		int unsigned hit_cnt;
		int unsigned above_cnt;
		int unsigned emitted;
		int k;
		peak_t pk;
		bin_wide = {1'b0, bin_count};
		for (k = 0; k < NUM_BANDS; k++) begin
			lo = (k == 0) ? '0 : band_edge[k-1];
			if (bin_wide >= lo && (k == NUM_BANDS - 1 || bin_wide < band_edge[k])
					&& mag > best_mag[k]) begin
				best_mag[k] = mag;
				best_bin[k] = bin_count;
				band_hit[k] = 1'b1;
			end
		end
		if (!last) begin
			if (bin_count != MAX_BIN_INDEX) bin_count++;
			return;
		end
		total = 0;
		hit_cnt = 0;
		for (k = 0; k < NUM_BANDS; k++) begin
			if (band_hit[k]) begin
				total += best_mag[k];
				hit_cnt++;
			end
		end
		// compare against the mean without dividing
		above_cnt = 0;
		for (k = 0; k < NUM_BANDS; k++) begin
			if (band_hit[k] && best_mag[k] * hit_cnt > total) above_cnt++;
		end
		emitted = 0;
		for (k = 0; k < NUM_BANDS; k++) begin
			if (band_hit[k] && best_mag[k] * hit_cnt > total) begin
				emitted++;
				pk.bin = best_bin[k];
				pk.window = window_count;
				pk.mag = best_mag[k];
				pk.last = (emitted == above_cnt);
				expected_peaks = {expected_peaks, pk};
			end
		end
		for (k = 0; k < NUM_BANDS; k++) begin
			best_mag[k] = '0;
			best_bin[k] = '0;
			band_hit[k] = 1'b0;
		end
		bin_count = '0;
		window_count++;
	endfunction

	// output side: stall pattern plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_SPARSE: out_stall <= ($urandom_range(0, 5) == 0);
				STALL_HALF: out_stall <= $urandom_range(0, 1);
				STALL_TOGGLE: out_stall <= ~out_stall;
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		peak_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_peaks.size() == 0) begin
				report_mismatch("peak with none pending", peak_bin, 0);
			end else begin
				want = expected_peaks.pop_front();
				peaks_checked++;
				if (peak_bin !== want.bin) report_mismatch("peak_bin", peak_bin, want.bin);
				if (peak_window !== want.window)
					report_mismatch("peak_window", peak_window, want.window);
				if (peak_magnitude !== want.mag)
					report_mismatch("peak_magnitude", peak_magnitude, want.mag);
				if (run_last !== want.last) report_mismatch("run_last", run_last, want.last);
			end
		end
	end

	task automatic send_bin(logic [15:0] mag, logic last);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		magnitude <= mag;
		window_end <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		track_bin(mag, last);
		bins_sent++;
		if (last) windows_sent++;
	endtask

	function automatic logic [15:0] rand_magnitude();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 4));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random_window(int len);
		int i;
		for (i = 0; i < len; i++) send_bin(rand_magnitude(), i == len - 1);
	endtask

	// stop offering, let every expected peak drain, then settle
	task automatic wait_idle(int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_peaks.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (idx <= REG_EDGE_FIVE) band_edge[idx] = value[EDGE_W-1:0];
		reg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read_check(logic [2:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== {{(32 - EDGE_W){1'b0}}, band_edge[idx]})
			report_mismatch("edge register read", prdata, band_edge[idx]);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_edges(logic [31:0] e1, logic [31:0] e2, logic [31:0] e3,
			logic [31:0] e4, logic [31:0] e5);
		int k;
		wait_idle(12);
		reg_write(REG_EDGE_ONE, e1);
		reg_write(REG_EDGE_TWO, e2);
		reg_write(REG_EDGE_THREE, e3);
		reg_write(REG_EDGE_FOUR, e4);
		reg_write(REG_EDGE_FIVE, e5);
		for (k = 0; k < NUM_EDGES; k++) reg_read_check(3'(k));
	endtask

	task automatic test_reset_defaults();
		logic [15:0] mags [6] = '{16'd100, 16'd200, 16'd50, 16'd200, 16'd0, 16'd7};
		int k;
		for (k = 0; k < NUM_EDGES; k++) reg_read_check(3'(k));
		// all bins land in the lowest band, so a single peak is never above the mean
		for (k = 0; k < 6; k++) send_bin(mags[k], k == 5);
	endtask

	task automatic test_band_basics();
		logic [15:0] mags [12] = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0007,
			16'h0007, 16'h0001, 16'h0003, 16'h8000, 16'h7FFF, 16'h0002, 16'hFFFF};
		int k;
		stall_mode = STALL_SPARSE;
		wait_idle(12);
		reg_write(REG_UNUSED_LO, 32'hFFFF_FFFF);
		reg_write(REG_UNUSED_HI, 32'h0000_0001);
		// upper bits of the first edge are dropped by the register
		set_edges(32'hFFFF_E002, 32'd4, 32'd6, 32'd8, 32'd10);
		for (k = 0; k < 12; k++) send_bin(mags[k], k == 11);
		for (k = 0; k < 3; k++) send_bin(16'd0, k == 2);
		send_bin(16'd5, 1'b1);
		// equal peaks in every band: nothing strictly above the mean
		for (k = 0; k < 12; k++) send_bin(16'd9, k == 11);
	endtask

	task automatic test_edge_order();
		logic [15:0] mags_a [8] = '{16'd5, 16'd9, 16'd9, 16'd2, 16'd7, 16'd0, 16'd1, 16'd3};
		logic [15:0] mags_b [8] = '{16'd4, 16'd1, 16'd6, 16'd6, 16'd2, 16'd8, 16'd3, 16'd9};
		int k;
		stall_mode = STALL_HALF;
		set_edges(32'd0, 32'd8191, 32'd3, 32'd3, 32'd4096);
		for (k = 0; k < 8; k++) send_bin(mags_a[k], k == 7);
		set_edges(32'd8191, 32'd2, 32'd5, 32'd1, 32'd6);
		for (k = 0; k < 8; k++) send_bin(mags_b[k], k == 7);
		set_edges(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		for (k = 0; k < 4; k++) send_bin(mags_b[k], k == 3);
		set_edges(32'd8191, 32'd8191, 32'd8191, 32'd8191, 32'd8191);
		for (k = 0; k < 4; k++) send_bin(mags_a[k], k == 3);
	endtask

	task automatic run_random_phase(int n_items, bit ordered, stall_mode_t mode, bit gaps);
		logic [31:0] v [NUM_EDGES];
		int acc;
		int k;
		int sent;
		int len;
		acc = 0;
		for (k = 0; k < NUM_EDGES; k++) begin
			if (ordered) begin
				acc += $urandom_range(0, 6);
				v[k] = acc;
				if ($urandom_range(0, 1)) v[k] = v[k] | ($urandom & 32'hFFFF_E000);
			end else begin
				v[k] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 30);
			end
		end
		set_edges(v[0], v[1], v[2], v[3], v[4]);
		stall_mode = mode;
		sender_gaps = gaps;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
			send_random_window(len);
			sent += len;
		end
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		run_random_phase(35, 1'b1, STALL_SPARSE, 1'b1);
		run_random_phase(35, 1'b0, STALL_HALF, 1'b1);
		run_random_phase(30, 1'b1, STALL_NONE, 1'b0);
		run_random_phase(30, 1'b0, STALL_TOGGLE, 1'b1);
	endtask

	task automatic test_backpressure();
		int k;
		set_edges(32'd1, 32'd2, 32'd3, 32'd4, 32'd5);
		stall_mode = STALL_NONE;
		sender_gaps = 1'b0;
		// short windows pile up behind the hold-off until the input stalls
		hold_request = 300;
		for (k = 0; k < 8; k++) send_random_window(5);
		wait_idle(0);
		sender_gaps = 1'b1;
		stall_mode = STALL_HALF;
		for (k = 0; k < 4; k++) send_random_window(7);
	endtask

	initial begin
		int k;
		for (k = 0; k < NUM_BANDS; k++) begin
			best_mag[k] = '0;
			best_bin[k] = '0;
			band_hit[k] = 1'b0;
		end
		band_edge[REG_EDGE_ONE] = EDGE_ONE_RST;
		band_edge[REG_EDGE_TWO] = EDGE_TWO_RST;
		band_edge[REG_EDGE_THREE] = EDGE_THREE_RST;
		band_edge[REG_EDGE_FOUR] = EDGE_FOUR_RST;
		band_edge[REG_EDGE_FIVE] = EDGE_FIVE_RST;
		bin_count = '0;
		window_count = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_band_basics();
		test_edge_order();
		test_random_traffic();
		test_backpressure();
		wait_idle(20);
		$display("run covered %0d bins in %0d windows, %0d peaks compared, %0d register writes",
			bins_sent, windows_sent, peaks_checked, reg_writes);
		$display("including unordered and out-of-range edges, equal peaks, empty windows, "
			, "long output hold-off; %0d mismatches", mismatches);
		if (mismatches == 0 && expected_peaks.size() == 0) begin
			$display("** spectral_band_peak_picker_core: PASSED **");
		end else begin
			$display("** spectral_band_peak_picker_core: FAILED **");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sbpp_pkg.sv
rtl/sbpp_front.sv
rtl/sbpp_queue.sv
rtl/sbpp_back.sv
rtl/spectral_band_peak_picker_core.sv
tb/testbench.sv
